/* src/egcd_pkg.sv */
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared types for the extended gcd core: sequencer states and the control
// and status groups passed between the sequencer and the division unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORDER,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_DONE
  } state_e;

  // sequencer to division unit
  typedef struct packed {
    logic start;
    logic run;
  } div_ctrl_t;

  // division unit to sequencer
  typedef struct packed {
    logic last;
  } div_stat_t;

endpackage

/* src/egcd_if.sv */
// ----------------------------------------------------------------------------
// egcd_in_if / egcd_out_if
// Valid/ready channels for operand beats and result beats.
// ----------------------------------------------------------------------------
interface egcd_in_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] a_value;
  logic signed [DATA_WIDTH-1:0] b_value;

  modport source (output valid, output a_value, output b_value, input ready);
  modport sink   (input valid, input a_value, input b_value, output ready);
endinterface

interface egcd_out_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic        [DATA_WIDTH-2:0] gcd_value;
  logic signed [DATA_WIDTH-1:0] coef_a;
  logic signed [DATA_WIDTH-1:0] coef_b;

  modport source (output valid, output gcd_value, output coef_a, output coef_b,
                  input ready);
  modport sink   (input valid, input gcd_value, input coef_a, input coef_b,
                  output ready);
endinterface

/* src/egcd_div_unit.sv */
// ----------------------------------------------------------------------------
// egcd_div_unit
// Shared restoring divider, one quotient bit per cycle, MSB first. Each
// quotient bit is folded Horner-style into the products quotient*coef_a and
// quotient*coef_b (modulo 2^DATA_WIDTH), so no multiplier is needed.
// ----------------------------------------------------------------------------
module egcd_div_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  egcd_pkg::div_ctrl_t     ctrl_i,
  input  logic [DATA_WIDTH-1:0]   dividend_i,
  input  logic [DATA_WIDTH-1:0]   divisor_i,
  input  logic [DATA_WIDTH-1:0]   coef_a_i,
  input  logic [DATA_WIDTH-1:0]   coef_b_i,
  output logic [DATA_WIDTH-1:0]   rem_o,
  output logic [DATA_WIDTH-1:0]   prod_a_o,
  output logic [DATA_WIDTH-1:0]   prod_b_o,
  output egcd_pkg::div_stat_t     stat_o
);

  localparam int CntW = $clog2(DATA_WIDTH);

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] dvd_q, dvd_d;
  logic [DATA_WIDTH-1:0] prod_a_q, prod_a_d;
  logic [DATA_WIDTH-1:0] prod_b_q, prod_b_d;
  logic [DATA_WIDTH:0]   trial;
  logic                  ge;

  // trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem_q, dvd_q[DATA_WIDTH-1]} - {1'b0, divisor_i};
  assign ge    = ~trial[DATA_WIDTH];

  // next values of the iteration registers
  always_comb begin
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    prod_a_d = prod_a_q;
    prod_b_d = prod_b_q;
    if (ctrl_i.start) begin
      cnt_d    = CntW'(DATA_WIDTH - 1);
      rem_d    = '0;
      dvd_d    = dividend_i;
      prod_a_d = '0;
      prod_b_d = '0;
    end else if (ctrl_i.run) begin
      cnt_d    = cnt_q - CntW'(1);
      rem_d    = ge ? trial[DATA_WIDTH-1:0] : {rem_q[DATA_WIDTH-2:0], dvd_q[DATA_WIDTH-1]};
      dvd_d    = {dvd_q[DATA_WIDTH-2:0], 1'b0};
      prod_a_d = {prod_a_q[DATA_WIDTH-2:0], 1'b0} + (ge ? coef_a_i : '0);
      prod_b_d = {prod_b_q[DATA_WIDTH-2:0], 1'b0} + (ge ? coef_b_i : '0);
    end
  end

  // counter needs reset, datapath does not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
  end

  assign rem_o       = rem_q;
  assign prod_a_o    = prod_a_q;
  assign prod_b_o    = prod_b_q;
  assign stat_o.last = (cnt_q == '0);

endmodule

/* src/extended_gcd_bezout_core.sv */
// ----------------------------------------------------------------------------
// extended_gcd_bezout_core
// Extended Euclid: gcd of two signed operands with Bezout coefficients.
// ----------------------------------------------------------------------------
// One operand beat is taken while the core is idle. in_i.ready then stays low
// until the result has been moved into the output register. The next operand
// beat may be taken while that result still waits on out_o. An item passes
// through set-up (IDLE, ORDER, CHECK), then a division and a record update for
// every Euclid step (one quotient bit per cycle on the shared shift-subtract
// unit), then ST_DONE, which passes the result to the output register and
// waits there while the previous result beat has not been taken.
// The number of division steps depends on the operands: none when one operand
// is zero, one when one magnitude divides the other, and at most about
// 1.44*DATA_WIDTH for consecutive Fibonacci numbers. The magnitude of the most
// negative operand is exact internally; a gcd of 2^(DATA_WIDTH-1) saturates to
// all ones. Coefficients wrap modulo 2^DATA_WIDTH.
module extended_gcd_bezout_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  egcd_in_if.sink           in_i,
  egcd_out_if.source        out_o
);

  localparam int W = DATA_WIDTH;

  egcd_pkg::state_e    state_q, state_d;
  egcd_pkg::div_ctrl_t div_ctrl;
  egcd_pkg::div_stat_t div_stat;

  // operand records: magnitude and the two coefficients
  logic [W-1:0] p_mag_q, p_mag_d, p_ca_q, p_ca_d, p_cb_q, p_cb_d;
  logic [W-1:0] q_mag_q, q_mag_d, q_ca_q, q_ca_d, q_cb_q, q_cb_d;
  logic [W-2:0] gcd_q, gcd_d;
  logic [W-1:0] res_ca_q, res_ca_d, res_cb_q, res_cb_d;
  logic         out_valid_q, out_valid_d;

  logic [W-1:0] dividend;
  logic [W-1:0] rem, prod_a, prod_b;
  logic [W-1:0] a_raw, b_raw;
  logic [W-1:0] one_w;

  assign a_raw    = in_i.a_value;
  assign b_raw    = in_i.b_value;
  assign one_w    = W'(1);
  assign dividend = (state_q == egcd_pkg::ST_UPDATE) ? q_mag_q : p_mag_q;

  egcd_div_unit #(
    .DATA_WIDTH (W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (dividend),
    .divisor_i  (q_mag_q),
    .coef_a_i   (q_ca_q),
    .coef_b_i   (q_cb_q),
    .rem_o      (rem),
    .prod_a_o   (prod_a),
    .prod_b_o   (prod_b),
    .stat_o     (div_stat)
  );

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= egcd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // record and result registers
  always_ff @(posedge clk_i) begin
    p_mag_q  <= p_mag_d;
    p_ca_q   <= p_ca_d;
    p_cb_q   <= p_cb_d;
    q_mag_q  <= q_mag_d;
    q_ca_q   <= q_ca_d;
    q_cb_q   <= q_cb_d;
    gcd_q    <= gcd_d;
    res_ca_q <= res_ca_d;
    res_cb_q <= res_cb_d;
  end

  // sequencer: next state, record updates and unit control
  always_comb begin
    state_d        = state_q;
    p_mag_d        = p_mag_q;
    p_ca_d         = p_ca_q;
    p_cb_d         = p_cb_q;
    q_mag_d        = q_mag_q;
    q_ca_d         = q_ca_q;
    q_cb_d         = q_cb_q;
    gcd_d          = gcd_q;
    res_ca_d       = res_ca_q;
    res_cb_d       = res_cb_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    div_ctrl.start = 1'b0;
    div_ctrl.run   = 1'b0;
    unique case (state_q)
      egcd_pkg::ST_IDLE: begin
        // fold each operand's sign into its own coefficient
        p_mag_d = a_raw[W-1] ? (W'(0) - a_raw) : a_raw;
        p_ca_d  = a_raw[W-1] ? '1 : one_w;
        p_cb_d  = '0;
        q_mag_d = b_raw[W-1] ? (W'(0) - b_raw) : b_raw;
        q_ca_d  = '0;
        q_cb_d  = b_raw[W-1] ? '1 : one_w;
        if (in_i.valid) begin
          state_d = egcd_pkg::ST_ORDER;
        end
      end
      egcd_pkg::ST_ORDER: begin
        // larger magnitude first, whole records swapped
        if (p_mag_q < q_mag_q) begin
          p_mag_d = q_mag_q;
          p_ca_d  = q_ca_q;
          p_cb_d  = q_cb_q;
          q_mag_d = p_mag_q;
          q_ca_d  = p_ca_q;
          q_cb_d  = p_cb_q;
        end
        state_d = egcd_pkg::ST_CHECK;
      end
      egcd_pkg::ST_CHECK: begin
        if (p_mag_q == '0) begin
          // both operands zero
          q_mag_d = '0;
          q_ca_d  = '0;
          q_cb_d  = '0;
          state_d = egcd_pkg::ST_DONE;
        end else if (q_mag_q == '0) begin
          // the nonzero operand's record is the answer
          q_mag_d = p_mag_q;
          q_ca_d  = p_ca_q;
          q_cb_d  = p_cb_q;
          state_d = egcd_pkg::ST_DONE;
        end else begin
          div_ctrl.start = 1'b1;
          state_d        = egcd_pkg::ST_DIV;
        end
      end
      egcd_pkg::ST_DIV: begin
        div_ctrl.run = 1'b1;
        if (div_stat.last) begin
          state_d = egcd_pkg::ST_UPDATE;
        end
      end
      egcd_pkg::ST_UPDATE: begin
        if (rem == '0) begin
          // divisor record is the answer
          state_d = egcd_pkg::ST_DONE;
        end else begin
          // shift records along and start the next division
          p_mag_d        = q_mag_q;
          p_ca_d         = q_ca_q;
          p_cb_d         = q_cb_q;
          q_mag_d        = rem;
          q_ca_d         = p_ca_q - prod_a;
          q_cb_d         = p_cb_q - prod_b;
          div_ctrl.start = 1'b1;
          state_d        = egcd_pkg::ST_DIV;
        end
      end
      egcd_pkg::ST_DONE: begin
        // move the answer into the output register once it is free
        if (!out_valid_q || out_o.ready) begin
          gcd_d       = q_mag_q[W-1] ? '1 : q_mag_q[W-2:0];
          res_ca_d    = q_ca_q;
          res_cb_d    = q_cb_q;
          out_valid_d = 1'b1;
          state_d     = egcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = egcd_pkg::ST_IDLE;
      end
    endcase
  end

  // channel outputs
  assign in_i.ready      = (state_q == egcd_pkg::ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.gcd_value = gcd_q;
  assign out_o.coef_a    = res_ca_q;
  assign out_o.coef_b    = res_cb_q;

`ifndef SYNTHESIS
  // a result beat on offer holds still until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=>
      (out_o.valid && $stable(out_o.gcd_value) &&
       $stable(out_o.coef_a) && $stable(out_o.coef_b)))
    else $error("result beat changed while waiting");

  // an accepted beat starts the ordering step
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == egcd_pkg::ST_ORDER))
    else $error("accepted beat did not start the sequence");

  // divisor is never zero while dividing
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == egcd_pkg::ST_DIV) |-> (q_mag_q != '0))
    else $error("division by zero in progress");

  // zero gcd only for the all-zero result
  a_zero_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.gcd_value == '0)) |->
      ((out_o.coef_a == '0) && (out_o.coef_b == '0)))
    else $error("zero gcd with nonzero coefficients");
`endif

endmodule
